[rtl/tsq_pkg.sv]
// Shared types and constants for the two-stack queue.
`timescale 1ns / 1ps
package tsq_pkg;

  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int WORD_W = 32;
  localparam int COUNT_W = 6;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [1:0] {
    K_ENQ,
    K_POP,
    K_PEEK,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [WORD_W-1:0] data;
  } cmd_t;

endpackage

[rtl/tsq_front.sv]
// Front end: accepts transactions, decodes the opcode and buffers commands.
`timescale 1ns / 1ps
module tsq_front
  import tsq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [WORD_W-1:0] data_in,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output cmd_t                     cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       decoded;

  always_comb begin
    decoded.data = data_in;
    unique case (opcode)
      OP_ENQUEUE: decoded.kind = K_ENQ;
      OP_DEQUEUE: decoded.kind = K_POP;
      OP_PEEK:    decoded.kind = K_PEEK;
      default:    decoded.kind = K_NOP;
    endcase
  end

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[rtl/tsq_back.sv]
// Back end: the two stacks, the refill sequencer and the result register.
`timescale 1ns / 1ps
module tsq_back
  import tsq_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  cmd_t                      cmd,
  output logic                      done,
  output logic signed [WORD_W-1:0]  data_out,
  output logic [1:0]                status,
  output logic [COUNT_W-1:0]        count
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int SW = (FW + 1 > COUNT_W) ? FW + 1 : COUNT_W;

  typedef enum logic [1:0] {
    IDLE,
    XFER_RD,
    XFER_WR,
    POP_RD
  } state_t;

  state_t            state;
  logic [FW-1:0]     in_fill;
  logic [FW-1:0]     out_fill;
  logic              is_pop;
  logic              resp_mem;
  logic [WORD_W-1:0] resp_word;

  logic [WORD_W-1:0] inbound [STACK_DEPTH];
  logic [WORD_W-1:0] outbound [STACK_DEPTH];
  logic [WORD_W-1:0] in_rd;
  logic [WORD_W-1:0] out_rd;

  logic              take;
  logic              in_full;
  logic              in_we;
  logic [FW-1:0]     in_fill_m1;
  logic [FW-1:0]     out_fill_m1;
  logic [SW-1:0]     total;

  assign cmd_ready   = (state == IDLE);
  assign take        = cmd_valid && cmd_ready;
  assign in_full     = (in_fill == FW'(STACK_DEPTH));
  assign in_we       = take && (cmd.kind == K_ENQ) && !in_full;
  assign in_fill_m1  = in_fill - FW'(1);
  assign out_fill_m1 = out_fill - FW'(1);
  assign total       = SW'(in_fill) + SW'(out_fill);
  assign count       = total[COUNT_W-1:0];
  assign data_out    = resp_mem ? out_rd : resp_word;

  // Inbound stack: push on enqueue, read top during refill.
  always_ff @(posedge clk) begin
    if (in_we) begin
      inbound[in_fill[AW-1:0]] <= cmd.data;
    end
    if (state == XFER_RD) begin
      in_rd <= inbound[in_fill_m1[AW-1:0]];
    end
  end

  // Outbound stack: fill during refill, read top for dequeue and peek.
  always_ff @(posedge clk) begin
    if (state == XFER_WR) begin
      outbound[out_fill[AW-1:0]] <= in_rd;
    end
    if (state == POP_RD) begin
      out_rd <= outbound[out_fill_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_fill   <= '0;
      out_fill  <= '0;
      is_pop    <= 1'b0;
      done      <= 1'b0;
      resp_mem  <= 1'b0;
      resp_word <= '0;
      status    <= ST_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (take) begin
            resp_mem  <= 1'b0;
            resp_word <= '0;
            status    <= ST_OK;
            is_pop    <= (cmd.kind == K_POP);
            unique case (cmd.kind)
              K_ENQ: begin
                done <= 1'b1;
                if (in_full) begin
                  status <= ST_FULL;
                end else begin
                  in_fill <= in_fill + FW'(1);
                end
              end
              K_POP, K_PEEK: begin
                if (in_fill == '0 && out_fill == '0) begin
                  done      <= 1'b1;
                  resp_word <= EMPTY_WORD;
                  status    <= ST_EMPTY;
                end else if (out_fill == '0) begin
                  state <= XFER_RD;
                end else begin
                  state <= POP_RD;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        XFER_RD: begin
          state <= XFER_WR;
        end
        XFER_WR: begin
          // Move one word per pass; oldest word lands on top last.
          in_fill  <= in_fill_m1;
          out_fill <= out_fill + FW'(1);
          state    <= (in_fill == FW'(1)) ? POP_RD : XFER_RD;
        end
        POP_RD: begin
          done     <= 1'b1;
          resp_mem <= 1'b1;
          status   <= ST_OK;
          if (is_pop) begin
            out_fill <= out_fill_m1;
          end
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (SW'(in_fill) + SW'(out_fill)) <= SW'(2 * STACK_DEPTH))
    else $error("stack fills exceed capacity");

  a_xfer_src: assert property (@(posedge clk) disable iff (rst)
    (state == XFER_RD || state == XFER_WR) |-> (in_fill != '0))
    else $error("refill running on empty inbound stack");

  a_empty_resp: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (in_fill == '0 && out_fill == '0))
    else $error("empty status with entries held");

  a_pop_src: assert property (@(posedge clk) disable iff (rst)
    (state == POP_RD) |-> (out_fill != '0))
    else $error("outbound read on empty stack");
`endif

endmodule

[rtl/two_stack_queue_top.sv]
// Top level of the two-stack queue: front decoder plus stack back end.
//
// Commands enter on start/opcode/data_in and are taken at a rising edge
// where start is high and busy is low. busy rises only when the two-entry
// command buffer between the decoder and the stack engine is full.
// Each command yields exactly one result: done is high for one cycle with
// data_out, status and count valid in that cycle. The receiver cannot stall.
// Enqueue, no-op and empty dequeue/peek pass the command buffer and give
// done from IDLE; dequeue/peek from a non-empty outbound stack also goes
// through POP_RD. When dequeue/peek finds the outbound stack empty, the
// refill sequencer moves the inbound stack over word by word (XFER_RD
// reads the inbound port, then XFER_WR writes the outbound port), then POP_RD.
// Throughput: one enqueue per cycle while the back end is in IDLE; it takes
// no new command until a dequeue/peek and any refill are done.
// Reset (synchronous, rst high) empties both stacks and the command buffer;
// stack memories keep stale contents that are never read.
`timescale 1ns / 1ps
module two_stack_queue_top
  import tsq_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [WORD_W-1:0] data_in,
  output logic                     done,
  output logic signed [WORD_W-1:0] data_out,
  output logic [1:0]               status,
  output logic [COUNT_W-1:0]       count
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  tsq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .data_in   (data_in),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tsq_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .done      (done),
    .data_out  (data_out),
    .status    (status),
    .count     (count)
  );

endmodule
